// ===== hdl/lhct_pkg.sv =====
// Shared constants, codes and types of the label hash chain table.
package lhct_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 65536;
    localparam int BUCKETS     = 1024;
    localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
    localparam int BUCKET_AW   = $clog2(BUCKETS);
    localparam int IDX_W       = ENTRY_AW + 1;

    // Field widths.
    localparam int OP_W       = 2;
    localparam int ID_W       = 32;
    localparam int OFS_W      = 32;
    localparam int SEC_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Hash and flag constants.
    localparam logic [ID_W-1:0] HASH_MUL   = 32'd65521;
    localparam logic [ID_W-1:0] HASH_ADD   = 32'd31;
    localparam int              HASH_SHIFT = 16;
    localparam int              FAR_SHIFT  = 20;

    // Empty chain link (-1).
    localparam logic [IDX_W-1:0] LINK_EMPTY = '1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INS_OFS = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_ABS = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BSS_SECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_SECTION = 1'd1;

    // Result kinds chosen by the controller.
    localparam int RES_SEL_W = 3;
    localparam logic [RES_SEL_W-1:0] RES_IGNORED  = 3'd0;
    localparam logic [RES_SEL_W-1:0] RES_FULL     = 3'd1;
    localparam logic [RES_SEL_W-1:0] RES_INSERTED = 3'd2;
    localparam logic [RES_SEL_W-1:0] RES_HIT      = 3'd3;
    localparam logic [RES_SEL_W-1:0] RES_MISS     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 capture;
        logic                 hash;
        logic                 insert;
        logic                 walk_load_head;
        logic                 walk_step;
        logic                 res_load;
        logic [RES_SEL_W-1:0] res_sel;
        logic                 out_load;
        logic                 clr_step;
    } lhct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_ok;
        logic            full;
        logic            head_empty;
        logic            hit;
        logic            next_empty;
        logic            clr_last;
        logic            out_free;
    } lhct_sts_t;

    // One chain entry as held in the link memory.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] next;
    } lhct_link_t;

    // Stored payload of one entry.
    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [SEC_W-1:0] section;
    } lhct_data_t;

endpackage

// ===== hdl/lhct_ctrl.sv =====
// Controller state machine of the label hash chain table.
module lhct_ctrl import lhct_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lhct_sts_t sts,
    output lhct_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_HEAD   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_WALK   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts the bucket clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash   = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD: begin
                // The bucket head is read in this cycle.
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next   = S_DONE;
                cmd.res_load = 1'b1;
                case (sts.op)
                    OP_INS_OFS, OP_INS_ABS: begin
                        if (!sts.id_ok) begin
                            cmd.res_sel = RES_IGNORED;
                        end else if (sts.full) begin
                            cmd.res_sel = RES_FULL;
                        end else begin
                            cmd.insert  = 1'b1;
                            cmd.res_sel = RES_INSERTED;
                        end
                    end
                    OP_LOOKUP: begin
                        if (sts.head_empty) begin
                            cmd.res_sel = RES_MISS;
                        end else begin
                            cmd.res_load       = 1'b0;
                            cmd.walk_load_head = 1'b1;
                            state_next         = S_WALK;
                        end
                    end
                    default: begin
                        cmd.res_sel = RES_IGNORED;
                    end
                endcase
            end
            S_WALK: begin
                // The entry read in the previous cycle is compared here.
                if (sts.hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_HIT;
                    state_next   = S_DONE;
                end else if (sts.next_empty) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_MISS;
                    state_next   = S_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lhct_dp.sv =====
// Datapath of the label hash chain table: hash, bucket heads, entries, result.
module lhct_dp import lhct_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic [OP_W-1:0]             s_op,
    input  logic signed [ID_W-1:0]      s_label_id,
    input  logic [OFS_W-1:0]            s_offset,
    input  logic [SEC_W-1:0]            s_section,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [IDX_W-1:0]     m_entry_index,
    output logic [STATUS_W-1:0]         m_status,
    output logic                        m_far_offset,
    input  lhct_cmd_t                   cmd,
    output lhct_sts_t                   sts
);

    // Configuration and control registers.
    logic [SEC_W-1:0]     bss_sec_reg;
    logic [SEC_W-1:0]     abs_sec_reg;
    logic [IDX_W-1:0]     count_reg;
    logic [BUCKET_AW-1:0] clr_cnt_reg;
    logic                 m_valid_reg;

    // Item registers.
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [SEC_W-1:0]  section_reg;
    logic [ID_W-1:0]   h1_reg;
    logic [ID_W-1:0]   h2_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  head_rd_reg;
    lhct_link_t        link_rd_reg;

    // Result registers.
    logic [IDX_W-1:0]    res_idx_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_far_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_far_reg;

    // Memories.
    logic [IDX_W-1:0] bucket_head_mem [BUCKETS];
    lhct_link_t       entry_link_mem  [MAX_ENTRIES];
    lhct_data_t       entry_data_mem  [MAX_ENTRIES];

    logic [BUCKET_AW-1:0] bucket;
    logic [ENTRY_AW-1:0]  link_raddr;
    logic [ENTRY_AW-1:0]  new_addr;
    logic                 far;
    lhct_data_t           new_data;

    assign bucket     = h2_reg[HASH_SHIFT +: BUCKET_AW];
    assign new_addr   = count_reg[ENTRY_AW-1:0];
    assign link_raddr = cmd.walk_step ? link_rd_reg.next[ENTRY_AW-1:0]
                                      : head_rd_reg[ENTRY_AW-1:0];

    // Far offset flag and the stored section of a new entry.
    always_comb begin
        far = (op_reg == OP_INS_OFS) && (offset_reg[OFS_W-1:FAR_SHIFT] != '0)
              && (section_reg != bss_sec_reg);
        new_data.offset  = offset_reg;
        new_data.section = (op_reg == OP_INS_OFS) ? section_reg : abs_sec_reg;
    end

    // Status back to the controller.
    always_comb begin
        sts.op         = op_reg;
        sts.id_ok      = (id_reg != '0) && !id_reg[ID_W-1];
        sts.full       = (count_reg >= IDX_W'(MAX_ENTRIES));
        sts.head_empty = head_rd_reg[IDX_W-1];
        sts.hit        = (link_rd_reg.id == id_reg);
        sts.next_empty = link_rd_reg.next[IDX_W-1];
        sts.clr_last   = (clr_cnt_reg == BUCKET_AW'(BUCKETS - 1));
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Control registers with reset: configuration, fill count, clear sweep, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bss_sec_reg <= '0;
            abs_sec_reg <= '0;
            count_reg   <= IDX_W'(1);
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BSS_SECTION: bss_sec_reg <= cfg_wr_data;
                    REG_ABS_SECTION: abs_sec_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.insert) begin
                count_reg <= count_reg + IDX_W'(1);
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + BUCKET_AW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, the two hash rounds and the chain cursor.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= s_op;
            id_reg      <= $unsigned(s_label_id);
            offset_reg  <= s_offset;
            section_reg <= s_section;
            h1_reg      <= $unsigned(s_label_id) * HASH_MUL + HASH_ADD;
        end
        if (cmd.hash) begin
            h2_reg <= h1_reg * HASH_MUL + HASH_ADD;
        end
        if (cmd.walk_load_head) begin
            cur_reg <= head_rd_reg;
        end else if (cmd.walk_step) begin
            cur_reg <= link_rd_reg.next;
        end
    end

    // Bucket head memory: cleared by the sweep, updated by inserts.
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            bucket_head_mem[clr_cnt_reg] <= LINK_EMPTY;
        end else if (cmd.insert) begin
            bucket_head_mem[bucket] <= count_reg;
        end
        head_rd_reg <= bucket_head_mem[bucket];
    end

    // Entry memories: a new entry links in front of its bucket's chain.
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            entry_link_mem[new_addr] <= '{id: id_reg, next: head_rd_reg};
            entry_data_mem[new_addr] <= new_data;
        end
        link_rd_reg <= entry_link_mem[link_raddr];
    end

    // Pending result and the output register.
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.res_sel)
                RES_FULL: begin
                    res_idx_reg    <= '0;
                    res_status_reg <= ST_FULL;
                    res_far_reg    <= 1'b0;
                end
                RES_INSERTED: begin
                    res_idx_reg    <= count_reg;
                    res_status_reg <= ST_OK;
                    res_far_reg    <= far;
                end
                RES_HIT: begin
                    res_idx_reg    <= cur_reg;
                    res_status_reg <= ST_OK;
                    res_far_reg    <= 1'b0;
                end
                RES_MISS: begin
                    res_idx_reg    <= LINK_EMPTY;
                    res_status_reg <= ST_NOT_FOUND;
                    res_far_reg    <= 1'b0;
                end
                default: begin
                    res_idx_reg    <= '0;
                    res_status_reg <= ST_IGNORED;
                    res_far_reg    <= 1'b0;
                end
            endcase
        end
        if (cmd.out_load) begin
            out_idx_reg    <= res_idx_reg;
            out_status_reg <= res_status_reg;
            out_far_reg    <= res_far_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_index = $signed(out_idx_reg);
    assign m_status      = out_status_reg;
    assign m_far_offset  = out_far_reg;

endmodule

// ===== hdl/label_hash_chain_table_top.sv =====
// An insert, an ignored item or an empty-bucket lookup shows its result without a chain walk;
// a lookup with a non-empty bucket walks its chain, one entry link read a cycle. A new item is
// accepted only once the result of the last has been taken into the output register.
// Reset (aresetn, synchronous, active low) clears the configuration, sets the fill count
// to one and starts a pass that empties all 1024 bucket heads; no item is taken
// during that pass. Configuration writes are taken at any time.
module label_hash_chain_table_top import lhct_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic signed [ID_W-1:0]  s_label_id,
    input  logic [OFS_W-1:0]        s_offset,
    input  logic [SEC_W-1:0]        s_section,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [IDX_W-1:0] m_entry_index,
    output logic [STATUS_W-1:0]     m_status,
    output logic                    m_far_offset
);

    lhct_cmd_t cmd;
    lhct_sts_t sts;

    // Sequencer for hashing, head lookup, insert and chain walk.
    lhct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hash, memories and result registers.
    lhct_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_op          (s_op),
        .s_label_id    (s_label_id),
        .s_offset      (s_offset),
        .s_section     (s_section),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_index (m_entry_index),
        .m_status      (m_status),
        .m_far_offset  (m_far_offset),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
